/* design/uvs_pkg.sv */
`timescale 1ns / 1ps
// Shared types, constants and tables for the UV sphere mesh generator.
// No dependencies.
package uvs_pkg;

  localparam int unsigned MAX_SEGMENTS = 255;
  localparam int unsigned CORDIC_STEPS = 16;

  // Long division: numerator width, divisor width, steps per stage.
  localparam int unsigned DIV_W      = 42;
  localparam int unsigned DEN_W      = 9;
  localparam int unsigned DIV_STEPS  = 6;
  localparam int unsigned DIV_STAGES = (DIV_W + DIV_STEPS - 1) / DIV_STEPS;

  // Rotator: datapath widths, iterations per stage.
  localparam int unsigned CRD_W         = 32;
  localparam int unsigned ANG_W         = 33;
  localparam int unsigned CRD_STEPS     = 4;
  localparam int unsigned CORDIC_STAGES = (CORDIC_STEPS + CRD_STEPS - 1) / CRD_STEPS;
  localparam int unsigned CORDIC_LAT    = CORDIC_STAGES + 1;

  // Pipeline index of the last stage before the output register.
  localparam int unsigned LAST_STG = DIV_STAGES + CORDIC_LAT + 4;

  localparam logic signed [CRD_W-1:0] CORDIC_GAIN = 32'sd652032874;

  localparam logic [31:0] ATAN_TURNS [24] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163, 32'd81
  };

  // Configuration register indexes.
  localparam logic [2:0] CFG_SEGMENTS = 3'd0;
  localparam logic [2:0] CFG_RADIUS_X = 3'd1;
  localparam logic [2:0] CFG_RADIUS_Y = 3'd2;
  localparam logic [2:0] CFG_RADIUS_Z = 3'd3;
  localparam logic [2:0] CFG_COLOR    = 3'd4;

  typedef struct packed {
    logic [7:0] ring;
    logic [7:0] column;
  } uvs_in_t;

  typedef struct packed {
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] pos_z;
    logic [16:0]        tex_u;
    logic [16:0]        tex_v;
    logic [31:0]        color_out;
    logic [47:0]        tri_first;
    logic [47:0]        tri_second;
    logic               quad_valid;
  } uvs_out_t;

  typedef struct packed {
    logic [47:0] tri_first;
    logic [47:0] tri_second;
    logic        quad_valid;
  } uvs_meta_t;

  typedef struct packed {
    logic [16:0] tex_u;
    logic [16:0] tex_v;
  } uvs_tex_t;

endpackage

/* design/uvs_div.sv */
`timescale 1ns / 1ps
// Pipelined restoring divider, a few quotient bits per stage.
// Depends on uvs_pkg.
module uvs_div (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  logic [uvs_pkg::DIV_W-1:0]     num_i,
  input  logic [uvs_pkg::DEN_W-1:0]     den_i,
  output logic [uvs_pkg::DIV_W-1:0]     quot_o
);

  // Remainder stays below the divisor, so it fits the divisor width.
  logic [uvs_pkg::DEN_W-1:0] rem_q [uvs_pkg::DIV_STAGES];
  logic [uvs_pkg::DEN_W-1:0] rem_d [uvs_pkg::DIV_STAGES];
  logic [uvs_pkg::DIV_W-1:0] nq_q  [uvs_pkg::DIV_STAGES];
  logic [uvs_pkg::DIV_W-1:0] nq_d  [uvs_pkg::DIV_STAGES];
  logic [uvs_pkg::DEN_W-1:0] den_q [uvs_pkg::DIV_STAGES];
  logic [uvs_pkg::DEN_W-1:0] den_d [uvs_pkg::DIV_STAGES];

  always_comb begin
    logic [uvs_pkg::DEN_W-1:0] r;
    logic [uvs_pkg::DIV_W-1:0] nq;
    logic [uvs_pkg::DEN_W-1:0] d;
    logic [uvs_pkg::DEN_W:0]   t;
    for (int s = 0; s < int'(uvs_pkg::DIV_STAGES); s++) begin
      if (s == 0) begin
        r  = '0;
        nq = num_i;
        d  = den_i;
      end else begin
        r  = rem_q[s-1];
        nq = nq_q[s-1];
        d  = den_q[s-1];
      end
      for (int k = 0; k < int'(uvs_pkg::DIV_STEPS); k++) begin
        if (s * int'(uvs_pkg::DIV_STEPS) + k < int'(uvs_pkg::DIV_W)) begin
          t  = {r, nq[uvs_pkg::DIV_W-1]};
          nq = {nq[uvs_pkg::DIV_W-2:0], 1'b0};
          if (t >= {1'b0, d}) begin
            t     = t - {1'b0, d};
            nq[0] = 1'b1;
          end
          r = t[uvs_pkg::DEN_W-1:0];
        end
      end
      rem_d[s] = r;
      nq_d[s]  = nq;
      den_d[s] = d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q <= rem_d;
      nq_q  <= nq_d;
      den_q <= den_d;
    end
  end

  assign quot_o = nq_q[uvs_pkg::DIV_STAGES-1];

endmodule

/* design/uvs_cordic.sv */
`timescale 1ns / 1ps
// Pipelined CORDIC rotator giving sine and cosine of a 32-bit turn phase in Q2.30.
// Depends on uvs_pkg.
module uvs_cordic (
  input  logic                                clk_i,
  input  logic                                en_i,
  input  logic [31:0]                         phase_i,
  output logic signed [uvs_pkg::CRD_W-1:0]    sin_o,
  output logic signed [uvs_pkg::CRD_W-1:0]    cos_o
);

  logic signed [uvs_pkg::CRD_W-1:0] x_q [uvs_pkg::CORDIC_STAGES];
  logic signed [uvs_pkg::CRD_W-1:0] x_d [uvs_pkg::CORDIC_STAGES];
  logic signed [uvs_pkg::CRD_W-1:0] y_q [uvs_pkg::CORDIC_STAGES];
  logic signed [uvs_pkg::CRD_W-1:0] y_d [uvs_pkg::CORDIC_STAGES];
  logic signed [uvs_pkg::ANG_W-1:0] z_q [uvs_pkg::CORDIC_STAGES];
  logic signed [uvs_pkg::ANG_W-1:0] z_d [uvs_pkg::CORDIC_STAGES];
  logic [uvs_pkg::CORDIC_STAGES-1:0] neg_q, neg_d;
  logic signed [uvs_pkg::CRD_W-1:0] sin_q, cos_q;

  always_comb begin
    logic signed [uvs_pkg::CRD_W-1:0] x, y, dx, dy;
    logic signed [uvs_pkg::ANG_W-1:0] z, at;
    logic [31:0] ph;
    logic        ng;
    for (int s = 0; s < int'(uvs_pkg::CORDIC_STAGES); s++) begin
      if (s == 0) begin
        // Second and third quadrants rotate by half a turn, results negated.
        ng = phase_i[31] ^ phase_i[30];
        ph = {phase_i[31] ^ ng, phase_i[30:0]};
        z  = $signed({ph[31], ph});
        x  = uvs_pkg::CORDIC_GAIN;
        y  = '0;
      end else begin
        ng = neg_q[s-1];
        x  = x_q[s-1];
        y  = y_q[s-1];
        z  = z_q[s-1];
      end
      for (int k = 0; k < int'(uvs_pkg::CRD_STEPS); k++) begin
        if (s * int'(uvs_pkg::CRD_STEPS) + k < int'(uvs_pkg::CORDIC_STEPS)) begin
          dx = y >>> (s * int'(uvs_pkg::CRD_STEPS) + k);
          dy = x >>> (s * int'(uvs_pkg::CRD_STEPS) + k);
          at = $signed({1'b0,
                uvs_pkg::ATAN_TURNS[5'(s * int'(uvs_pkg::CRD_STEPS) + k)]});
          if (!z[uvs_pkg::ANG_W-1]) begin
            x = x - dx;
            y = y + dy;
            z = z - at;
          end else begin
            x = x + dx;
            y = y - dy;
            z = z + at;
          end
        end
      end
      x_d[s]   = x;
      y_d[s]   = y;
      z_d[s]   = z;
      neg_d[s] = ng;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q   <= x_d;
      y_q   <= y_d;
      z_q   <= z_d;
      neg_q <= neg_d;
      cos_q <= neg_q[uvs_pkg::CORDIC_STAGES-1] ? -x_q[uvs_pkg::CORDIC_STAGES-1]
                                                :  x_q[uvs_pkg::CORDIC_STAGES-1];
      sin_q <= neg_q[uvs_pkg::CORDIC_STAGES-1] ? -y_q[uvs_pkg::CORDIC_STAGES-1]
                                                :  y_q[uvs_pkg::CORDIC_STAGES-1];
    end
  end

  assign sin_o = sin_q;
  assign cos_o = cos_q;

endmodule

/* design/uv_sphere_mesh_generator.sv */
`timescale 1ns / 1ps
// Top level of the UV sphere mesh generator: input stage, dividers, rotators,
// scaling multipliers and output skid buffer. Depends on uvs_pkg, uvs_div, uvs_cordic.
//
// Usage
//   Input channel: one transaction carries a ring and column index; taken when
//   in_valid_i is high and in_stall_o low. Output channel: one transaction per
//   input carries the vertex position, texture coordinate, colour and the two
//   triangles of the quad it closes; taken when out_valid_o is high and
//   out_stall_i low. Results leave in input order.
//   Throughput: one transaction per cycle while in_stall_o is low. Path from
//   acceptance to out_valid_o: the index register loads at acceptance, then
//   the 7-stage divider, the 5-stage rotator, the 4 multiply and round stages
//   and the output register follow.
//   Configuration: cfg_we_i writes cfg_data_i into register cfg_idx_i
//   (segments, radius x/y/z, colour); unused indexes are ignored. Write only
//   while no transaction is in flight.
//   Reset: the pipeline empties and the registers take segments 64, radii
//   4096 and an all-ones colour.
//   Stall: the output register plus a one-entry skid buffer keep the pipeline
//   running while the output stalls; in_stall_o rises only once the skid buffer
//   holds a transaction, and the whole pipeline then holds until it drains.
module uv_sphere_mesh_generator (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  uvs_pkg::uvs_in_t in_data_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output uvs_pkg::uvs_out_t out_data_o,
  input  logic             cfg_we_i,
  input  logic [2:0]       cfg_idx_i,
  input  logic [31:0]      cfg_data_i
);

  localparam int unsigned LAST  = uvs_pkg::LAST_STG;
  localparam int unsigned DIVO  = uvs_pkg::DIV_STAGES;
  localparam int unsigned TEXN  = LAST - DIVO;

  // ---------------- configuration registers ----------------
  logic [7:0]         segments_q;
  logic signed [15:0] radius_x_q, radius_y_q, radius_z_q;
  logic [31:0]        color_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      segments_q <= 8'd64;
      radius_x_q <= 16'sd4096;
      radius_y_q <= 16'sd4096;
      radius_z_q <= 16'sd4096;
      color_q    <= 32'hFFFF_FFFF;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        uvs_pkg::CFG_SEGMENTS: segments_q <= cfg_data_i[7:0];
        uvs_pkg::CFG_RADIUS_X: radius_x_q <= $signed(cfg_data_i[15:0]);
        uvs_pkg::CFG_RADIUS_Y: radius_y_q <= $signed(cfg_data_i[15:0]);
        uvs_pkg::CFG_RADIUS_Z: radius_z_q <= $signed(cfg_data_i[15:0]);
        uvs_pkg::CFG_COLOR:    color_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // ---------------- pipeline control ----------------
  // Every stage moves on en; bubbles travel as cleared valid bits.
  logic          en;
  logic [LAST:0] v_q;
  logic          skid_valid_q, skid_valid_d;
  logic          out_valid_q, out_valid_d;

  assign en         = !skid_valid_q;
  assign in_stall_o = skid_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[LAST-1:0], in_valid_i};
    end
  end

  // ---------------- stage 0: clamp indices ----------------
  logic [7:0] seg_eff, ring_c, col_c;
  logic [7:0] seg_q, ring_q, col_q;

  always_comb begin
    seg_eff = (segments_q == 8'd0) ? 8'd1 : segments_q;
    if (seg_eff > 8'(uvs_pkg::MAX_SEGMENTS)) seg_eff = 8'(uvs_pkg::MAX_SEGMENTS);
    ring_c = (in_data_i.ring   > seg_eff) ? seg_eff : in_data_i.ring;
    col_c  = (in_data_i.column > seg_eff) ? seg_eff : in_data_i.column;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      seg_q  <= seg_eff;
      ring_q <= ring_c;
      col_q  <= col_c;
    end
  end

  // ---------------- triangle indices, carried alongside ----------------
  uvs_pkg::uvs_meta_t meta_d;
  uvs_pkg::uvs_meta_t meta_q [LAST];

  always_comb begin
    logic [15:0] base, a, b, c, d;
    base = 16'({1'b0, seg_q} + 9'd1) * 16'(ring_q - 8'd1);
    a    = base + 16'(col_q);
    b    = a + 16'({1'b0, seg_q} + 9'd1);
    c    = b + 16'd1;
    d    = a + 16'd1;
    meta_d.quad_valid = (ring_q != 8'd0) && (col_q < seg_q);
    meta_d.tri_first  = meta_d.quad_valid ? {c, b, a} : 48'd0;
    meta_d.tri_second = meta_d.quad_valid ? {d, c, a} : 48'd0;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      meta_q[0] <= meta_d;
      for (int s = 1; s < int'(LAST); s++) meta_q[s] <= meta_q[s-1];
    end
  end

  // ---------------- dividers: phases and texture coordinates ----------------
  logic [uvs_pkg::DEN_W-1:0] den;
  logic [uvs_pkg::DIV_W-1:0] q_inc, q_az, q_u, q_v;

  assign den = {seg_q, 1'b0};

  // round(ring * 2^31 / S)
  uvs_div u_div_inc (
    .clk_i, .en_i(en), .num_i({2'b0, ring_q, 24'b0, seg_q}), .den_i(den), .quot_o(q_inc)
  );
  // round(column * 2^32 / S), wrapped to 32 bits
  uvs_div u_div_az (
    .clk_i, .en_i(en), .num_i({1'b0, col_q, 25'b0, seg_q}), .den_i(den), .quot_o(q_az)
  );
  uvs_div u_div_u (
    .clk_i, .en_i(en), .num_i({17'b0, col_q, 9'b0, seg_q}), .den_i(den), .quot_o(q_u)
  );
  uvs_div u_div_v (
    .clk_i, .en_i(en), .num_i({17'b0, ring_q, 9'b0, seg_q}), .den_i(den), .quot_o(q_v)
  );

  uvs_pkg::uvs_tex_t tex_q [TEXN];

  always_ff @(posedge clk_i) begin
    if (en) begin
      tex_q[0].tex_u <= q_u[16:0];
      tex_q[0].tex_v <= 17'd65536 - q_v[16:0];
      for (int s = 1; s < int'(TEXN); s++) tex_q[s] <= tex_q[s-1];
    end
  end

  // ---------------- rotators ----------------
  logic signed [uvs_pkg::CRD_W-1:0] sin_inc, cos_inc, sin_az, cos_az;

  uvs_cordic u_cordic_inc (
    .clk_i, .en_i(en), .phase_i(q_inc[31:0]), .sin_o(sin_inc), .cos_o(cos_inc)
  );
  uvs_cordic u_cordic_az (
    .clk_i, .en_i(en), .phase_i(q_az[31:0]), .sin_o(sin_az), .cos_o(cos_az)
  );

  // ---------------- scaling: four stages ----------------
  logic signed [63:0] m1_x_q, m1_y_q;
  logic signed [31:0] m1_z_q;
  logic signed [63:0] m2_sx, m2_sy;
  logic signed [33:0] m2_x_q, m2_y_q, m2_z_q;
  logic signed [49:0] m3_x_q, m3_y_q, m3_z_q;
  logic signed [15:0] pos_x_q, pos_y_q, pos_z_q;

  function automatic logic signed [15:0] round_sat(input logic signed [49:0] p);
    logic signed [49:0] s;
    logic signed [19:0] r;
    s = p + 50'sd536870912;
    r = $signed(s[49:30]);
    if (r > 20'sd32767)       round_sat = 16'sd32767;
    else if (r < -20'sd32768) round_sat = -16'sd32768;
    else                      round_sat = r[15:0];
  endfunction

  assign m2_sx = m1_x_q + 64'sd536870912;
  assign m2_sy = m1_y_q + 64'sd536870912;

  always_ff @(posedge clk_i) begin
    if (en) begin
      m1_x_q  <= 64'(sin_inc) * 64'(cos_az);
      m1_y_q  <= 64'(sin_inc) * 64'(sin_az);
      m1_z_q  <= cos_inc;
      m2_x_q  <= $signed(m2_sx[63:30]);
      m2_y_q  <= $signed(m2_sy[63:30]);
      m2_z_q  <= 34'(m1_z_q);
      m3_x_q  <= 50'(radius_x_q) * 50'(m2_x_q);
      m3_y_q  <= 50'(radius_y_q) * 50'(m2_y_q);
      m3_z_q  <= 50'(radius_z_q) * 50'(m2_z_q);
      pos_x_q <= round_sat(m3_x_q);
      pos_y_q <= round_sat(m3_y_q);
      pos_z_q <= round_sat(m3_z_q);
    end
  end

  // ---------------- output register and skid buffer ----------------
  uvs_pkg::uvs_out_t pipe_data, out_q, out_d, skid_q, skid_d;
  logic pipe_v, taken;

  always_comb begin
    pipe_data.pos_x      = pos_x_q;
    pipe_data.pos_y      = pos_y_q;
    pipe_data.pos_z      = pos_z_q;
    pipe_data.tex_u      = tex_q[TEXN-1].tex_u;
    pipe_data.tex_v      = tex_q[TEXN-1].tex_v;
    pipe_data.color_out  = color_q;
    pipe_data.tri_first  = meta_q[LAST-1].tri_first;
    pipe_data.tri_second = meta_q[LAST-1].tri_second;
    pipe_data.quad_valid = meta_q[LAST-1].quad_valid;
  end

  assign pipe_v = v_q[LAST] && en;
  assign taken  = out_valid_q && !out_stall_i;

  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_d        = out_q;
    skid_d       = skid_q;
    if (skid_valid_q) begin
      if (taken) begin
        out_d        = skid_q;
        skid_valid_d = 1'b0;
      end
    end else if (pipe_v) begin
      if (!out_valid_q || taken) begin
        out_d       = pipe_data;
        out_valid_d = 1'b1;
      end else begin
        skid_d       = pipe_data;
        skid_valid_d = 1'b1;
      end
    end else if (taken) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // ---------------- assertions ----------------
  a_skid_implies_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid buffer holds a transaction behind an empty output");

  a_skid_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (skid_valid_q && !out_stall_i) |=> !skid_valid_q)
    else $error("skid buffer did not drain after output was taken");

  a_quad_tex_v: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.quad_valid) |-> (out_data_o.tex_v != 17'd65536))
    else $error("closed quad on the first ring");

  a_open_quad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_data_o.quad_valid) |->
      (out_data_o.tri_first == 48'd0 && out_data_o.tri_second == 48'd0))
    else $error("triangle indices set on an open quad");

endmodule

/* verif/tb_uv_sphere_mesh_generator.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the UV sphere mesh generator.
// Depends on uvs_pkg and uv_sphere_mesh_generator; predicts every vertex in SystemVerilog.
module tb_uv_sphere_mesh_generator;

  localparam int unsigned LATENCY = 17;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_stall_o;
  uvs_pkg::uvs_in_t  in_data_i = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  uvs_pkg::uvs_out_t out_data_o;
  logic      cfg_we_i = 1'b0;
  logic [2:0] cfg_idx_i = '0;
  logic [31:0] cfg_data_i = '0;

  // Idle control: when quiet is set neither side idles.
  bit quiet = 1'b0;
  int fail_count = 0;
  int vertex_count = 0;
  int quad_count = 0;

  // Predictor copy of the registers.
  logic [7:0]         seg_reg;
  logic signed [15:0] rx_reg, ry_reg, rz_reg;
  logic [31:0]        color_reg;

  uvs_pkg::uvs_out_t vertex_queue[$];

  uv_sphere_mesh_generator i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  always #10 clk_i = ~clk_i;

  // Generous fixed limit on the whole run.
  initial begin
    #40ms;
    $display("CHECKS FAILED");
    $finish;
  end

  // Arithmetic shift right is floor on signed operands.
  function automatic longint round_shift(longint v, int n);
    return (v + (64'sd1 <<< (n - 1))) >>> n;
  endfunction

  // CORDIC rotator on a phase in 2^-32 turns; returns sine and cosine in Q2.30.
  task automatic rotate_phase(input logic [31:0] phase, output longint s, output longint c);
    longint x, y, z, dx, dy;
    bit flip;
    x = 652032874;
    y = 0;
    flip = 1'b0;
    if (phase >= 32'h4000_0000 && phase < 32'hC000_0000) begin
      phase = phase - 32'h8000_0000;
      flip = 1'b1;
    end
    z = longint'(signed'(phase));
    for (int k = 0; k < uvs_pkg::CORDIC_STEPS; k++) begin
      dx = y >>> k;
      dy = x >>> k;
      if (z >= 0) begin
        x -= dx; y += dy; z -= longint'(uvs_pkg::ATAN_TURNS[k]);
      end else begin
        x += dx; y -= dy; z += longint'(uvs_pkg::ATAN_TURNS[k]);
      end
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endtask

  function automatic logic [15:0] scale_radius(logic signed [15:0] r, longint f);
    longint p;
    p = round_shift(longint'(r) * f, 30);
    if (p > 32767) p = 32767;
    if (p < -32768) p = -32768;
    return p[15:0];
  endfunction

  // Expected vertex for one ring/column pair under the current registers.
  task automatic predict_vertex(input uvs_pkg::uvs_in_t item, output uvs_pkg::uvs_out_t v);
    longint unsigned sg, i, j, t, ph_i, ph_a;
    longint unsigned a, b, c, d;
    longint si, ci, sa, ca;
    sg = seg_reg;
    if (sg < 1) sg = 1;
    if (sg > uvs_pkg::MAX_SEGMENTS) sg = uvs_pkg::MAX_SEGMENTS;
    i = item.ring;
    j = item.column;
    if (i > sg) i = sg;
    if (j > sg) j = sg;
    ph_i = ((i << 32) + sg) / (2 * sg);
    ph_a = ((j << 33) + sg) / (2 * sg);
    rotate_phase(ph_i[31:0], si, ci);
    rotate_phase(ph_a[31:0], sa, ca);
    v = '0;
    v.pos_x = scale_radius(rx_reg, round_shift(si * ca, 30));
    v.pos_y = scale_radius(ry_reg, round_shift(si * sa, 30));
    v.pos_z = scale_radius(rz_reg, ci);
    v.tex_u = 17'((j * 131072 + sg) / (2 * sg));
    v.tex_v = 17'(65536 - (i * 131072 + sg) / (2 * sg));
    v.color_out = color_reg;
    t = sg + 1;
    if (i >= 1 && j < sg) begin
      a = t * (i - 1) + j;
      b = t * i + j;
      c = t * i + j + 1;
      d = t * (i - 1) + j + 1;
      v.tri_first  = {c[15:0], b[15:0], a[15:0]};
      v.tri_second = {d[15:0], c[15:0], a[15:0]};
      v.quad_valid = 1'b1;
    end
  endtask

  // Register write, mirrored into the predictor. Only called when idle.
  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      uvs_pkg::CFG_SEGMENTS: seg_reg   = val[7:0];
      uvs_pkg::CFG_RADIUS_X: rx_reg    = val[15:0];
      uvs_pkg::CFG_RADIUS_Y: ry_reg    = val[15:0];
      uvs_pkg::CFG_RADIUS_Z: rz_reg    = val[15:0];
      uvs_pkg::CFG_COLOR:    color_reg = val;
      default: ;
    endcase
  endtask

  // One input transaction; valid stays high across back-to-back sends.
  task automatic send_point(input logic [7:0] ring, input logic [7:0] column);
    uvs_pkg::uvs_out_t v;
    uvs_pkg::uvs_in_t item;
    item.ring = ring;
    item.column = column;
    if (!quiet && $urandom_range(99) < 33) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    predict_vertex(item, v);
    vertex_queue = {vertex_queue, v};
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // Called at the edge that took the last transaction.
  task automatic go_idle();
    int guard;
    in_valid_i <= 1'b0;
    guard = 0;
    while (vertex_queue.size() != 0 && guard < 200000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (LATENCY + 4) @(posedge clk_i);
  endtask

  // Receiver: random stall, checks each accepted transaction.
  always @(posedge clk_i) begin
    uvs_pkg::uvs_out_t exp_v;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (vertex_queue.size() == 0) begin
          $display("%0t: unexpected vertex %h", $time, out_data_o);
          fail_count++;
        end else begin
          exp_v = vertex_queue.pop_front();
          vertex_count++;
          if (exp_v.quad_valid) quad_count++;
          if (out_data_o !== exp_v) begin
            $display("%0t: vertex mismatch expected %h actual %h", $time, exp_v, out_data_o);
            fail_count++;
          end
        end
      end
      out_stall_i <= !quiet && ($urandom_range(99) < 33);
    end
  end

  task automatic test_reset_defaults();
    send_point(8'd0, 8'd0);
    send_point(8'd32, 8'd16);
    send_point(8'd64, 8'd63);
    send_point(8'd255, 8'd255);
    go_idle();
  endtask

  // Extremes of segments (0 acts as 1), radii and colour, clamping and an unused index.
  task automatic test_directed_extremes();
    write_reg(uvs_pkg::CFG_SEGMENTS, 32'd0);
    send_point(8'd0, 8'd0);
    send_point(8'd1, 8'd0);
    send_point(8'd200, 8'd9);
    go_idle();
    write_reg(uvs_pkg::CFG_SEGMENTS, 32'd255);
    write_reg(uvs_pkg::CFG_RADIUS_X, 32'h0000_7FFF);
    write_reg(uvs_pkg::CFG_RADIUS_Y, 32'h0000_8000);
    write_reg(uvs_pkg::CFG_RADIUS_Z, 32'hFFFF_8000);
    write_reg(uvs_pkg::CFG_COLOR, 32'h0000_0000);
    write_reg(3'd7, 32'h1234_5678);
    send_point(8'd255, 8'd254);
    send_point(8'd128, 8'd64);
    send_point(8'd1, 8'd255);
    send_point(8'd127, 8'd191);
    go_idle();
    write_reg(uvs_pkg::CFG_SEGMENTS, 32'd1);
    write_reg(uvs_pkg::CFG_COLOR, 32'hA5C3_0FF0);
    send_point(8'd1, 8'd0);
    send_point(8'd0, 8'd1);
    send_point(8'd255, 8'd255);
    go_idle();
  endtask

  // Random phases: mostly full sweeps of a small grid, plus noise points.
  task automatic test_random_grids();
    logic [7:0] s;
    int sent;
    sent = 0;
    while (sent < 1850) begin
      write_reg(uvs_pkg::CFG_SEGMENTS,
                $urandom_range(3) == 0 ? $urandom_range(255) : $urandom_range(12, 1));
      write_reg(uvs_pkg::CFG_RADIUS_X, $urandom());
      write_reg(uvs_pkg::CFG_RADIUS_Y, $urandom());
      write_reg(uvs_pkg::CFG_RADIUS_Z, $urandom_range(1) ? $urandom() : 32'd4096);
      write_reg(uvs_pkg::CFG_COLOR, $urandom());
      s = (seg_reg == 0) ? 8'd1 : seg_reg;
      quiet = (sent > 800 && sent < 1100);
      if (s <= 12) begin
        for (int r = 0; r <= s; r++)
          for (int c = 0; c <= s; c++) begin
            send_point(8'(r), 8'(c));
            sent++;
          end
      end
      repeat (40) begin
        send_point(8'($urandom()), 8'($urandom()));
        sent++;
      end
      go_idle();
    end
    quiet = 1'b0;
  endtask

  // Sender holds off until every vertex is back, then resumes.
  task automatic test_drain_pause();
    write_reg(uvs_pkg::CFG_SEGMENTS, 32'd8);
    repeat (10) send_point(8'($urandom_range(9)), 8'($urandom_range(9)));
    in_valid_i <= 1'b0;
    wait (vertex_queue.size() == 0);
    repeat (10) send_point(8'($urandom_range(9)), 8'($urandom_range(9)));
    go_idle();
  endtask

  initial begin
    seg_reg = 8'd64;
    rx_reg = 16'sd4096;
    ry_reg = 16'sd4096;
    rz_reg = 16'sd4096;
    color_reg = 32'hFFFF_FFFF;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_reset_defaults();
    test_directed_extremes();
    test_drain_pause();
    test_random_grids();
    go_idle();
    if (vertex_queue.size() != 0) begin
      $display("%0t: %0d vertices never arrived", $time, vertex_queue.size());
      fail_count++;
    end
    $display("Covered %0d vertices, %0d with closed quads,", vertex_count, quad_count);
    $display("across many segment, radius and colour settings under random stalls.");
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule

/* uv_sphere_mesh_generator.f */
design/uvs_pkg.sv
design/uvs_div.sv
design/uvs_cordic.sv
design/uv_sphere_mesh_generator.sv
verif/tb_uv_sphere_mesh_generator.sv
